### hw/rtl/epoch_seconds_to_calendar_macros.svh
// Assertion macros shared by the calendar conversion RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Check that is disabled while reset is high.
`define ESC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define ESC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/esc_pkg.sv
// Shared types and constants for the epoch-seconds to calendar converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned InWidth = 35;

  // Accepted span: 1900-01-01 00:00:00 through 2399-12-31 23:59:59.
  localparam logic signed [InWidth-1:0] SpanLow  = -35'sd2208988800;
  localparam logic signed [InWidth-1:0] SpanHigh = 35'sd13569465599;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
  } clock_fields_t;

  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [8:0] years_since_1900;
    logic [8:0] day_of_year;
  } date_fields_t;

endpackage

### hw/rtl/esc_time_unit.sv
// Time-of-day and weekday pipeline: splits the seconds within a day into
// hour, minute and second, and the day count into a weekday. Uses esc_pkg.
`timescale 1ns / 1ps
module esc_time_unit
  import esc_pkg::*;
(
  input  logic          clk,
  input  logic [17:0]   days,
  input  logic [16:0]   rem,
  output clock_fields_t fields
);

  // Stage 1: reciprocal products for rem / 3600 and (days + 1) / 7.
  logic [26:0] ph;
  logic [36:0] pw;
  logic [16:0] rem1;
  logic [17:0] dp1;

  // Stage 2: hour, seconds within the hour, weekday.
  logic [4:0]  hour2;
  logic [11:0] r2;
  logic [2:0]  wday2;

  // Stage 3: reciprocal product for minutes.
  logic [20:0] pmin;
  logic [11:0] r3;
  logic [4:0]  hour3;
  logic [2:0]  wday3;

  // Stage 4 and alignment delay to match the date pipeline.
  clock_fields_t dly [5];

  logic [17:0] dp1_sum;
  logic [4:0]  hour_q;
  logic [15:0] week_q;
  logic [5:0]  minute_q;

  assign dp1_sum  = days + 18'd1;
  assign hour_q   = ph[25:21];
  assign week_q   = pw[36:21];
  assign minute_q = pmin[19:14];

  always_ff @(posedge clk) begin
    ph   <= 27'(rem[16:4]) * 27'd9321;
    pw   <= 37'(dp1_sum) * 37'd299594;
    rem1 <= rem;
    dp1  <= dp1_sum;

    hour2 <= hour_q;
    r2    <= 12'(rem1 - 17'(hour_q) * 17'd3600);
    wday2 <= 3'(dp1 - 18'(week_q) * 18'd7);

    pmin  <= 21'(r2[11:2]) * 21'd1093;
    r3    <= r2;
    hour3 <= hour2;
    wday3 <= wday2;

    dly[0].second  <= 6'(r3 - 12'(minute_q) * 12'd60);
    dly[0].minute  <= minute_q;
    dly[0].hour    <= hour3;
    dly[0].weekday <= wday3;
    dly[1] <= dly[0];
    dly[2] <= dly[1];
    dly[3] <= dly[2];
    dly[4] <= dly[3];
  end

  assign fields = dly[4];

endmodule

### hw/rtl/esc_date_unit.sv
// Calendar date pipeline: turns a day count since 1900-01-01 into year,
// month, day of month and day of year over eight stages. Uses esc_pkg.
`timescale 1ns / 1ps
module esc_date_unit
  import esc_pkg::*;
(
  input  logic         clk,
  input  logic [17:0]  days,
  output date_fields_t fields
);

  // First day of each month in a year that starts on March 1.
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // Era 1 starts on 2000-03-01, era 0 on 1600-03-01.
  logic        era1, era2, era3, era4, era5, era6, era7;
  logic [17:0] doe1, doe2, doe3, doe4, doe5;
  logic [6:0]  qa2;
  logic [2:0]  qb2;
  logic        qc2;
  logic [17:0] yn3;
  logic [8:0]  yoe4, yoe5, yoe6, yoe7;
  logic [16:0] y365;
  logic [1:0]  q100;
  logic [8:0]  doy6, doy7;
  logic        leap6, leap7;
  logic [3:0]  mp7;
  date_fields_t out_q;

  logic [36:0] py;
  logic [15:0] dq;
  logic [32:0] pa, pb;
  logic [17:0] ym;
  logic [22:0] pm;
  logic [8:0]  year_adj;

  assign dq = doe1[17:2];
  assign pa = 33'(dq) * 33'd91930;
  assign pb = 33'(dq) * 33'd117594;
  assign py = 37'(yn3) * 37'd367720;
  assign ym = 18'(yoe4) * 18'd656;
  assign pm = 23'(11'(doy6) * 11'd5 + 11'd2) * 23'd3427;

  always_comb begin
    year_adj = 9'(10'(yoe7) + (era7 ? 10'd400 : 10'd0)
               + ((mp7 >= 4'd10) ? 10'd1 : 10'd0) - 10'd300);
  end

  always_ff @(posedge clk) begin
    era1 <= (days >= 18'd36584);
    doe1 <= (days >= 18'd36584) ? days - 18'd36584 : days + 18'd109513;

    era2 <= era1;
    doe2 <= doe1;
    qa2  <= pa[31:25];
    qb2  <= pb[32:30];
    qc2  <= (doe1 == 18'd146096);

    era3 <= era2;
    doe3 <= doe2;
    yn3  <= doe2 - 18'(qa2) + 18'(qb2) - 18'(qc2);

    era4 <= era3;
    doe4 <= doe3;
    yoe4 <= py[35:27];

    era5 <= era4;
    doe5 <= doe4;
    yoe5 <= yoe4;
    y365 <= 17'(yoe4) * 17'd365;
    q100 <= ym[17:16];

    era6 <= era5;
    yoe6 <= yoe5;
    doy6 <= 9'(doe5 - 18'(y365) - 18'(yoe5[8:2]) + 18'(q100));
    // Leap when divisible by 4 and not by 100, unless it is the first year of the era.
    leap6 <= (yoe5[1:0] == 2'd0) &&
             ((yoe5 != 9'(q100) * 9'd100) || (yoe5 == 9'd0));

    era7  <= era6;
    yoe7  <= yoe6;
    doy7  <= doy6;
    leap7 <= leap6;
    mp7   <= pm[22:19];

    out_q.day_of_month     <= 5'(doy7 - MonthStart[mp7] + 9'd1);
    out_q.month_index      <= (mp7 < 4'd10) ? mp7 + 4'd2 : mp7 - 4'd10;
    out_q.years_since_1900 <= year_adj;
    out_q.day_of_year      <= (mp7 >= 4'd10) ? doy7 - 9'd306
                              : doy7 + 9'd59 + 9'(leap7);
  end

  assign fields = out_q;

endmodule

### hw/rtl/epoch_seconds_to_calendar.sv
// Each start passes through the valid shift register and the done register to the done strobe.
// Throughput: one word per cycle; busy is always low and the pipeline never stalls.
// The depth is set by the constant-reciprocal multiplies of the date path.
// Reset clears the valid pipeline only; results are not held back by the receiver.
// Uses esc_pkg, esc_time_unit, esc_date_unit and the assertion macro header.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_macros.svh"
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [InWidth-1:0] epoch_seconds,
  output logic                      done,
  output logic [5:0]                second,
  output logic [5:0]                minute,
  output logic [4:0]                hour,
  output logic [4:0]                day_of_month,
  output logic [3:0]                month_index,
  output logic [8:0]                years_since_1900,
  output logic [2:0]                weekday,
  output logic [8:0]                day_of_year,
  output logic                      out_of_range
);

  localparam int unsigned Depth = 11;

  logic [Depth-1:0] vld_sr;
  logic [Depth-1:0] oor_sr;

  logic [33:0] t_a, t_b;
  logic [54:0] p1_b;
  logic [17:0] days_c;
  logic [16:0] rem_c;

  logic          oor_in;
  logic [35:0]   t_sum;
  logic [17:0]   days_q;
  clock_fields_t clk_f;
  date_fields_t  date_f;
  logic          oor_zeroed;
  logic          fields_legal;

  assign busy   = 1'b0;
  assign oor_in = (epoch_seconds < SpanLow) || (epoch_seconds > SpanHigh);
  assign t_sum  = 36'(signed'(epoch_seconds)) + 36'd2208988800;
  assign days_q = p1_b[54:37];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
      done   <= 1'b0;
    end else begin
      vld_sr <= {vld_sr[Depth-2:0], start};
      done   <= vld_sr[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    oor_sr <= {oor_sr[Depth-2:0], oor_in};
    t_a    <= t_sum[33:0];
    // Seconds divided by 86400 as (t >> 7) / 675 through a reciprocal.
    p1_b   <= 55'(t_a[33:7]) * 55'd203613265;
    t_b    <= t_a;
    days_c <= days_q;
    rem_c  <= 17'(t_b - 34'(days_q) * 34'd86400);

    if (oor_sr[Depth-1]) begin
      second           <= '0;
      minute           <= '0;
      hour             <= '0;
      weekday          <= '0;
      day_of_month     <= '0;
      month_index      <= '0;
      years_since_1900 <= '0;
      day_of_year      <= '0;
    end else begin
      second           <= clk_f.second;
      minute           <= clk_f.minute;
      hour             <= clk_f.hour;
      weekday          <= clk_f.weekday;
      day_of_month     <= date_f.day_of_month;
      month_index      <= date_f.month_index;
      years_since_1900 <= date_f.years_since_1900;
      day_of_year      <= date_f.day_of_year;
    end
    out_of_range <= oor_sr[Depth-1];
  end

  esc_time_unit u_time (
    .clk    (clk),
    .days   (days_c),
    .rem    (rem_c),
    .fields (clk_f)
  );

  esc_date_unit u_date (
    .clk    (clk),
    .days   (days_c),
    .fields (date_f)
  );

  assign oor_zeroed = (second == 6'd0) && (hour == 5'd0) && (day_of_month == 5'd0) &&
                      (years_since_1900 == 9'd0);
  assign fields_legal = (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) &&
                        (day_of_month != 5'd0) && (month_index < 4'd12) &&
                        (weekday < 3'd7) && (day_of_year < 9'd366);

  `ESC_ASSERT(a_latency, clk, rst, start |-> ##12 done, "word did not emerge after 12 cycles")
  `ESC_ASSERT(a_no_spurious, clk, rst, !start |-> ##12 !done, "done without a started word")
  `ESC_ASSERT(a_oor_zero, clk, rst, done && out_of_range |-> oor_zeroed, "result not zeroed")
  `ESC_ASSERT(a_fields_ok, clk, rst, done && !out_of_range |-> fields_legal, "field out of range")
  `ESC_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")

endmodule
